>>> design/sor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sor_pkg;

    localparam int MAX_SAMPLES = 256;
    // Holds the interval count n and the sample count n + 1.
    localparam int SW = $clog2(MAX_SAMPLES + 2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 4;

    localparam int DIV_STEPS = 32;
    localparam int DSTEP_W = $clog2(DIV_STEPS);
    localparam int QUOT_W = 17;
    localparam int QSTEP_W = $clog2(QUOT_W);
    localparam int ROOT_STAGES = 32;

    localparam logic [30:0] SIZE_FLOOR = 31'd655;
    localparam logic [30:0] MARGIN_FLOOR = 31'd6554;
    localparam logic [30:0] MARGIN_RESET = 31'd65536;
    localparam logic [8:0] SAMPLES_RESET = 9'd16;
    localparam logic [17:0] ONE_Q16 = 18'd65536;
    localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        REG_MARGIN  = 2'd0,
        REG_DANGER  = 2'd1,
        REG_SAMPLES = 2'd2
    } sor_reg_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } sor_front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_DRAIN,
        BK_DIV,
        BK_RESULT
    } sor_back_state_t;

    // One classified obstacle, ready for the sampling back end.
    typedef struct packed {
        logic               skip;
        logic               danger;
        logic               last;
        logic               is_box;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               negx;
        logic               negy;
        logic [31:0]        qx;
        logic [31:0]        qy;
        logic [SW-1:0]      rx;
        logic [SW-1:0]      ry;
        logic [SW-1:0]      n;
        logic [30:0]        hx;
        logic [30:0]        hy;
        logic [30:0]        margin;
    } sor_entry_t;

endpackage
`default_nettype wire

>>> design/sor_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sor_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic               is_box;
    logic               is_danger;
    logic               last_obstacle;

    modport source (
        output valid, start_x, start_y, goal_x, goal_y, center_x, center_y,
               extent_x, extent_y, is_box, is_danger, last_obstacle,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, goal_x, goal_y, center_x, center_y,
               extent_x, extent_y, is_box, is_danger, last_obstacle,
        output ready
    );
endinterface
`default_nettype wire

>>> design/sor_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sor_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] obstacle_risk;
    logic [23:0] risk_sum;
    logic        is_final;

    modport source (
        output valid, obstacle_risk, risk_sum, is_final,
        input  ready
    );
    modport sink (
        input  valid, obstacle_risk, risk_sum, is_final,
        output ready
    );
endinterface
`default_nettype wire

>>> design/sor_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sor_front
    import sor_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sor_in_if.sink           in_ch,
    input  wire logic [30:0] margin_cfg,
    input  wire logic        danger_en,
    input  wire logic [8:0]  sample_count,
    output sor_entry_t       entry,
    output logic             entry_valid,
    input  wire logic        entry_ready
);

    sor_front_state_t   state_reg, state_next;
    sor_entry_t         entry_reg, entry_next;
    logic [DSTEP_W-1:0] step_reg, step_next;

    logic [SW-1:0]      n_val;
    logic [30:0]        margin_val;
    logic [30:0]        half_x, half_y;
    logic [32:0]        ddx, ddy, adx, ady;
    logic [SW:0]        trial_x, trial_y;
    logic               bit_x, bit_y;

    always_comb
    begin
        if (int'(sample_count) < 2)
        begin
            n_val = SW'(2);
        end
        else if (int'(sample_count) > MAX_SAMPLES)
        begin
            n_val = SW'(MAX_SAMPLES);
        end
        else
        begin
            n_val = SW'(sample_count);
        end
    end

    assign margin_val = (margin_cfg < MARGIN_FLOOR) ? MARGIN_FLOOR : margin_cfg;
    assign half_x = {1'b0, in_ch.extent_x[30:1]};
    assign half_y = {1'b0, in_ch.extent_y[30:1]};
    assign ddx = {in_ch.goal_x[31], in_ch.goal_x} - {in_ch.start_x[31], in_ch.start_x};
    assign ddy = {in_ch.goal_y[31], in_ch.goal_y} - {in_ch.start_y[31], in_ch.start_y};
    assign adx = ddx[32] ? (33'd0 - ddx) : ddx;
    assign ady = ddy[32] ? (33'd0 - ddy) : ddy;

    // One quotient bit per cycle of |delta| / n, both axes together.
    assign trial_x = {entry_reg.rx, entry_reg.qx[31]};
    assign trial_y = {entry_reg.ry, entry_reg.qy[31]};
    assign bit_x = (trial_x >= {1'b0, entry_reg.n});
    assign bit_y = (trial_y >= {1'b0, entry_reg.n});

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        step_next = step_reg;
        in_ch.ready = (state_reg == FR_IDLE);
        entry_valid = (state_reg == FR_PUSH);
        unique case (state_reg)
            FR_IDLE:
            begin
                if (in_ch.valid)
                begin
                    entry_next.skip = in_ch.is_danger & ~danger_en;
                    entry_next.danger = in_ch.is_danger;
                    entry_next.last = in_ch.last_obstacle;
                    entry_next.is_box = in_ch.is_box;
                    entry_next.sx = in_ch.start_x;
                    entry_next.sy = in_ch.start_y;
                    entry_next.cx = in_ch.center_x;
                    entry_next.cy = in_ch.center_y;
                    entry_next.negx = ddx[32];
                    entry_next.negy = ddy[32];
                    entry_next.qx = adx[31:0];
                    entry_next.qy = ady[31:0];
                    entry_next.rx = '0;
                    entry_next.ry = '0;
                    entry_next.n = n_val;
                    if (in_ch.is_box)
                    begin
                        entry_next.hx = (half_x < SIZE_FLOOR) ? SIZE_FLOOR : half_x;
                    end
                    else
                    begin
                        entry_next.hx = (in_ch.extent_x < SIZE_FLOOR) ? SIZE_FLOOR
                                                                      : in_ch.extent_x;
                    end
                    entry_next.hy = (half_y < SIZE_FLOOR) ? SIZE_FLOOR : half_y;
                    entry_next.margin = margin_val;
                    step_next = '0;
                    state_next = (in_ch.is_danger & ~danger_en) ? FR_PUSH : FR_DIV;
                end
            end
            FR_DIV:
            begin
                entry_next.qx = {entry_reg.qx[30:0], bit_x};
                entry_next.qy = {entry_reg.qy[30:0], bit_y};
                entry_next.rx = bit_x ? SW'(trial_x - {1'b0, entry_reg.n}) : trial_x[SW-1:0];
                entry_next.ry = bit_y ? SW'(trial_y - {1'b0, entry_reg.n}) : trial_y[SW-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == DSTEP_W'(DIV_STEPS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (entry_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        step_reg <= step_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

>>> design/sor_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sor_queue
    import sor_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  sor_entry_t       in_entry,
    input  wire logic        in_valid,
    output logic             in_ready,
    output sor_entry_t       out_entry,
    output logic             out_valid,
    input  wire logic        out_ready
);

    sor_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push = in_valid & in_ready;
    assign pop = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule
`default_nettype wire

>>> design/sor_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sor_back
    import sor_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  sor_entry_t       entry,
    input  wire logic        entry_valid,
    output logic             entry_ready,
    sor_out_if.source        out_ch
);

    sor_back_state_t    state_reg, state_next;
    sor_entry_t         item_reg, item_next;

    // Sample generator: floor(i * |delta| / n) kept as quotient and remainder.
    logic [31:0]        aqx_reg, aqx_next, aqy_reg, aqy_next;
    logic [SW-1:0]      arx_reg, arx_next, ary_reg, ary_next;
    logic [SW-1:0]      idx_reg, idx_next;
    logic [SW:0]        rsum_x, rsum_y;
    logic [32:0]        px, py;

    // Distance pipeline.
    logic               s1_v_reg, s1_v_next;
    logic signed [33:0] s1_dx_reg, s1_dx_next, s1_dy_reg, s1_dy_next;
    logic               s2_v_reg;
    logic [31:0]        s2_a_reg, s2_a_next, s2_b_reg, s2_b_next;
    logic signed [34:0] s2_adj_reg, s2_adj_next;
    logic               s3_v_reg;
    logic [63:0]        s3_sa_reg, s3_sb_reg;
    logic signed [34:0] s3_adj_reg;
    logic [64:0]        sq_sum;

    logic [33:0]        abs_dx, abs_dy;
    logic signed [33:0] qx, qy, mx;

    logic               rt_v   [ROOT_STAGES + 1];
    logic               rt_sat [ROOT_STAGES + 1];
    logic signed [34:0] rt_adj [ROOT_STAGES + 1];
    logic [63:0]        rt_val [ROOT_STAGES + 1];
    logic [31:0]        rt_root[ROOT_STAGES + 1];
    logic [34:0]        rt_rem [ROOT_STAGES + 1];
    logic [63:0]        rt_val_next [ROOT_STAGES];
    logic [31:0]        rt_root_next[ROOT_STAGES];
    logic [34:0]        rt_rem_next [ROOT_STAGES];
    logic [34:0]        rem_shift   [ROOT_STAGES];
    logic [34:0]        root_trial  [ROOT_STAGES];

    logic [32:0]        hyp;
    logic signed [34:0] sample_dist;

    // Per-item accumulation.
    logic signed [34:0] min_reg, min_next;
    logic [SW-1:0]      inside_reg, inside_next;
    logic [SW-1:0]      done_reg, done_next;

    // Risk divider: 17 quotient bits, one per cycle.
    logic [30:0]        drem_reg, drem_next;
    logic [30:0]        dvsr_reg, dvsr_next;
    logic [QUOT_W-1:0]  dq_reg, dq_next;
    logic [QSTEP_W-1:0] dstep_reg, dstep_next;
    logic [17:0]        base_reg, base_next;
    logic [17:0]        risk_reg, risk_next;
    logic [31:0]        dtrial;
    logic               dbit;
    logic [47:0]        dividend;
    logic signed [34:0] margin_s;
    logic [34:0]        margin_gap;

    // Result side.
    logic               out_v_reg, out_v_next;
    logic [17:0]        out_risk_reg, out_risk_next;
    logic [23:0]        out_total_reg, out_total_next;
    logic               out_final_reg, out_final_next;
    logic [23:0]        total_reg, total_next;
    logic [19:0]        risk3;
    logic [17:0]        risk_eff;
    logic [24:0]        total_sum;
    logic [23:0]        total_sat;

    // Sample point and offset from the center.
    assign px = {item_reg.sx[31], item_reg.sx} +
                (item_reg.negx ? (33'd0 - {1'b0, aqx_reg}) : {1'b0, aqx_reg});
    assign py = {item_reg.sy[31], item_reg.sy} +
                (item_reg.negy ? (33'd0 - {1'b0, aqy_reg}) : {1'b0, aqy_reg});
    assign s1_dx_next = $signed({px[32], px}) - $signed({{2{item_reg.cx[31]}}, item_reg.cx});
    assign s1_dy_next = $signed({py[32], py}) - $signed({{2{item_reg.cy[31]}}, item_reg.cy});
    assign rsum_x = {1'b0, arx_reg} + {1'b0, item_reg.rx};
    assign rsum_y = {1'b0, ary_reg} + {1'b0, item_reg.ry};

    // Box and circle operands for the root.
    assign abs_dx = s1_dx_reg[33] ? 34'(-s1_dx_reg) : 34'(s1_dx_reg);
    assign abs_dy = s1_dy_reg[33] ? 34'(-s1_dy_reg) : 34'(s1_dy_reg);
    assign qx = $signed(abs_dx) - $signed({3'b0, item_reg.hx});
    assign qy = $signed(abs_dy) - $signed({3'b0, item_reg.hy});
    assign mx = (qx > qy) ? qx : qy;

    always_comb
    begin
        if (item_reg.is_box)
        begin
            s2_a_next = (qx > 0) ? qx[31:0] : 32'd0;
            s2_b_next = (qy > 0) ? qy[31:0] : 32'd0;
            s2_adj_next = (mx < 0) ? 35'(mx) : 35'sd0;
        end
        else
        begin
            s2_a_next = abs_dx[31:0];
            s2_b_next = abs_dy[31:0];
            s2_adj_next = -$signed({4'b0, item_reg.hx});
        end
    end

    assign sq_sum = {1'b0, s3_sa_reg} + {1'b0, s3_sb_reg};

    // Integer root, one result bit per stage.
    always_comb
    begin
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            rem_shift[k] = {rt_rem[k][32:0], rt_val[k][63:62]};
            root_trial[k] = {1'b0, rt_root[k], 2'b01};
            rt_val_next[k] = {rt_val[k][61:0], 2'b00};
            if (rem_shift[k] >= root_trial[k])
            begin
                rt_rem_next[k] = rem_shift[k] - root_trial[k];
                rt_root_next[k] = {rt_root[k][30:0], 1'b1};
            end
            else
            begin
                rt_rem_next[k] = rem_shift[k];
                rt_root_next[k] = {rt_root[k][30:0], 1'b0};
            end
        end
    end

    assign hyp = rt_sat[ROOT_STAGES] ? 33'h1_0000_0000 : {1'b0, rt_root[ROOT_STAGES]};
    assign sample_dist = $signed({2'b0, hyp}) + rt_adj[ROOT_STAGES];

    assign margin_s = $signed({4'b0, item_reg.margin});
    assign margin_gap = 35'(margin_s - min_reg);
    assign dtrial = {drem_reg, dq_reg[QUOT_W-1]};
    assign dbit = (dtrial >= {1'b0, dvsr_reg});

    assign risk3 = ({2'b0, risk_reg} + {1'b0, risk_reg, 1'b0}) >> 2;
    assign risk_eff = item_reg.skip ? 18'd0 : (item_reg.danger ? risk3[17:0] : risk_reg);
    assign total_sum = {1'b0, total_reg} + {7'b0, risk_eff};
    assign total_sat = total_sum[24] ? TOTAL_MAX : total_sum[23:0];

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        aqx_next = aqx_reg;
        aqy_next = aqy_reg;
        arx_next = arx_reg;
        ary_next = ary_reg;
        idx_next = idx_reg;
        s1_v_next = 1'b0;
        min_next = min_reg;
        inside_next = inside_reg;
        done_next = done_reg;
        drem_next = drem_reg;
        dvsr_next = dvsr_reg;
        dq_next = dq_reg;
        dstep_next = dstep_reg;
        base_next = base_reg;
        risk_next = risk_reg;
        dividend = '0;
        out_v_next = out_v_reg & ~out_ch.ready;
        out_risk_next = out_risk_reg;
        out_total_next = out_total_reg;
        out_final_next = out_final_reg;
        total_next = total_reg;
        entry_ready = 1'b0;

        if (rt_v[ROOT_STAGES])
        begin
            if (done_reg == '0 || sample_dist < min_reg)
            begin
                min_next = sample_dist;
            end
            if (sample_dist <= 0)
            begin
                inside_next = inside_reg + 1'b1;
            end
            done_next = done_reg + 1'b1;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                entry_ready = 1'b1;
                if (entry_valid)
                begin
                    item_next = entry;
                    aqx_next = '0;
                    aqy_next = '0;
                    arx_next = '0;
                    ary_next = '0;
                    idx_next = '0;
                    inside_next = '0;
                    done_next = '0;
                    risk_next = '0;
                    state_next = entry.skip ? BK_RESULT : BK_SWEEP;
                end
            end
            BK_SWEEP:
            begin
                s1_v_next = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (rsum_x >= {1'b0, item_reg.n})
                begin
                    arx_next = SW'(rsum_x - {1'b0, item_reg.n});
                    aqx_next = aqx_reg + item_reg.qx + 32'd1;
                end
                else
                begin
                    arx_next = rsum_x[SW-1:0];
                    aqx_next = aqx_reg + item_reg.qx;
                end
                if (rsum_y >= {1'b0, item_reg.n})
                begin
                    ary_next = SW'(rsum_y - {1'b0, item_reg.n});
                    aqy_next = aqy_reg + item_reg.qy + 32'd1;
                end
                else
                begin
                    ary_next = rsum_y[SW-1:0];
                    aqy_next = aqy_reg + item_reg.qy;
                end
                if (idx_reg == item_reg.n)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (done_reg == item_reg.n + 1'b1)
                begin
                    dstep_next = '0;
                    if (min_reg <= 0)
                    begin
                        dividend = 48'(inside_reg) << 16;
                        dvsr_next = 31'(item_reg.n) + 31'd1;
                        base_next = ONE_Q16;
                        state_next = BK_DIV;
                    end
                    else if (min_reg < margin_s)
                    begin
                        dividend = {1'b0, margin_gap[30:0], 16'd0};
                        dvsr_next = item_reg.margin;
                        base_next = '0;
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        risk_next = '0;
                        state_next = BK_RESULT;
                    end
                    drem_next = dividend[47:QUOT_W];
                    dq_next = dividend[QUOT_W-1:0];
                end
            end
            BK_DIV:
            begin
                drem_next = dbit ? 31'(dtrial - {1'b0, dvsr_reg}) : dtrial[30:0];
                dq_next = {dq_reg[QUOT_W-2:0], dbit};
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == QSTEP_W'(QUOT_W - 1))
                begin
                    risk_next = base_reg + {1'b0, dq_reg[QUOT_W-2:0], dbit};
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                if (!out_v_reg || out_ch.ready)
                begin
                    out_v_next = 1'b1;
                    out_risk_next = risk_eff;
                    out_total_next = total_sat;
                    out_final_next = item_reg.last;
                    total_next = item_reg.last ? 24'd0 : total_sat;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            out_v_reg <= 1'b0;
            total_reg <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            for (int k = 0; k <= ROOT_STAGES; k++)
            begin
                rt_v[k] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            total_reg <= total_next;
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            rt_v[0] <= s3_v_reg;
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                rt_v[k + 1] <= rt_v[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        aqx_reg <= aqx_next;
        aqy_reg <= aqy_next;
        arx_reg <= arx_next;
        ary_reg <= ary_next;
        idx_reg <= idx_next;
        s1_dx_reg <= s1_dx_next;
        s1_dy_reg <= s1_dy_next;
        s2_a_reg <= s2_a_next;
        s2_b_reg <= s2_b_next;
        s2_adj_reg <= s2_adj_next;
        s3_sa_reg <= s2_a_reg * s2_a_reg;
        s3_sb_reg <= s2_b_reg * s2_b_reg;
        s3_adj_reg <= s2_adj_reg;
        rt_val[0] <= sq_sum[63:0];
        rt_sat[0] <= sq_sum[64];
        rt_adj[0] <= s3_adj_reg;
        rt_root[0] <= '0;
        rt_rem[0] <= '0;
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            rt_val[k + 1] <= rt_val_next[k];
            rt_root[k + 1] <= rt_root_next[k];
            rt_rem[k + 1] <= rt_rem_next[k];
            rt_sat[k + 1] <= rt_sat[k];
            rt_adj[k + 1] <= rt_adj[k];
        end
        min_reg <= min_next;
        inside_reg <= inside_next;
        done_reg <= done_next;
        drem_reg <= drem_next;
        dvsr_reg <= dvsr_next;
        dq_reg <= dq_next;
        dstep_reg <= dstep_next;
        base_reg <= base_next;
        risk_reg <= risk_next;
        out_risk_reg <= out_risk_next;
        out_total_reg <= out_total_next;
        out_final_reg <= out_final_next;
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.obstacle_risk = out_risk_reg;
    assign out_ch.risk_sum = out_total_reg;
    assign out_ch.is_final = out_final_reg;

endmodule
`default_nettype wire

>>> design/segment_obstacle_risk.sv
// Each word's n + 1 samples, n being the clamped interval count, pass through
// the back end's 36-stage distance and root pipeline, then, when the minimum lies
// inside the margin, a 17-step divider; a skipped danger zone bypasses both. The
// back end takes a new word only when idle, after registering the previous result.
// The front's 32-step divider runs in parallel behind a two-word queue.
// Reset is asynchronous and active low; it restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module segment_obstacle_risk
    import sor_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    sor_in_if.sink                  in_ch,
    sor_out_if.source               out_ch,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [30:0] margin_reg, margin_next;
    logic        danger_en_reg, danger_en_next;
    logic [8:0]  samples_reg, samples_next;
    logic        cfg_write;
    sor_reg_t    cfg_sel;

    sor_entry_t  front_entry, queue_entry;
    logic        front_valid, front_ready;
    logic        queue_valid, queue_ready;

    assign pready = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel = sor_reg_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        margin_next = margin_reg;
        danger_en_next = danger_en_reg;
        samples_next = samples_reg;
        prdata = '0;
        unique case (cfg_sel)
            REG_MARGIN:
            begin
                prdata = {1'b0, margin_reg};
                if (cfg_write)
                begin
                    margin_next = pwdata[30:0];
                end
            end
            REG_DANGER:
            begin
                prdata = {31'd0, danger_en_reg};
                if (cfg_write)
                begin
                    danger_en_next = pwdata[0];
                end
            end
            REG_SAMPLES:
            begin
                prdata = {23'd0, samples_reg};
                if (cfg_write)
                begin
                    samples_next = pwdata[8:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
            danger_en_reg <= 1'b0;
            samples_reg <= SAMPLES_RESET;
        end
        else
        begin
            margin_reg <= margin_next;
            danger_en_reg <= danger_en_next;
            samples_reg <= samples_next;
        end
    end

    sor_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .margin_cfg   (margin_reg),
        .danger_en    (danger_en_reg),
        .sample_count (samples_reg),
        .entry        (front_entry),
        .entry_valid  (front_valid),
        .entry_ready  (front_ready)
    );

    sor_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (front_entry),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_entry (queue_entry),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    sor_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (queue_entry),
        .entry_valid (queue_valid),
        .entry_ready (queue_ready),
        .out_ch      (out_ch)
    );

`ifndef NO_ASSERTIONS
    a_risk_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.obstacle_risk <= 18'd131072))
        else $error("obstacle risk above two");

    a_total_covers_risk: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ({6'd0, out_ch.obstacle_risk} <= out_ch.risk_sum))
        else $error("total risk below this obstacle's risk");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("front end took a second word while busy");
`endif

endmodule
`default_nettype wire
